@@ sv/rmdp_pkg.sv @@
// ----------------------------------------------------------------------------
// rmdp_pkg
// Types and constants for the ROI median depth projector.
// ----------------------------------------------------------------------------
package rmdp_pkg;

   localparam int MaxSamples  = 4096;
   localparam int MaxImageDim = 4096;
   localparam int AddrW       = $clog2(MaxSamples);
   localparam int CountW      = $clog2(MaxSamples + 1);

   localparam logic [0:0] OP_BOX   = 1'b0;
   localparam logic [0:0] OP_PIXEL = 1'b1;

   localparam logic [2:0] ST_VALID      = 3'd0;
   localparam logic [2:0] ST_BAD_CONFIG = 3'd1;
   localparam logic [2:0] ST_BAD_INTR   = 3'd2;
   localparam logic [2:0] ST_BAD_BOX    = 3'd3;
   localparam logic [2:0] ST_BAD_IMAGE  = 3'd4;
   localparam logic [2:0] ST_FEW_DEPTHS = 3'd5;

   localparam logic [2:0] CSR_MIN_DEPTH   = 3'd0;
   localparam logic [2:0] CSR_MAX_DEPTH   = 3'd1;
   localparam logic [2:0] CSR_ROI_RATIO   = 3'd2;
   localparam logic [2:0] CSR_MIN_SAMPLES = 3'd3;
   localparam logic [2:0] CSR_FOCAL_X     = 3'd4;
   localparam logic [2:0] CSR_FOCAL_Y     = 3'd5;
   localparam logic [2:0] CSR_PRINC_X     = 3'd6;
   localparam logic [2:0] CSR_PRINC_Y     = 3'd7;

   typedef struct packed {
      logic [0:0]  op;
      logic [15:0] box_ctr_u;
      logic [15:0] box_ctr_v;
      logic [15:0] box_width;
      logic [15:0] box_height;
      logic [12:0] img_cols;
      logic [12:0] img_rows;
      logic [11:0] pixel_u;
      logic [11:0] pixel_v;
      logic [15:0] pixel_depth;
      logic [0:0]  pixel_finite;
      logic [0:0]  last_pixel;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [12:0]        sample_count;
      logic [16:0]        median_depth;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
   } rsp_type;

endpackage

@@ sv/roi_median_depth_projector_unit.sv @@
// ----------------------------------------------------------------------------
// roi_median_depth_projector_unit
// Median depth inside a box region and pinhole back-projection of its center.
// ----------------------------------------------------------------------------
//  channel  ports                            direction
//  req      start, busy, req_data            in  (box or pixel word)
//  rsp      rsp_valid, rsp_data              out (one-cycle strobe)
//  csr      csr_we, csr_index, csr_wdata     in  (write only)
//
//  box and pixel words are taken while busy is low; pixels can stream
//  back to back. a last pixel with a bad config, image or box, too few
//  depths or bad intrinsics answers on the next cycle. otherwise the
//  median is a bitwise radix select over the sample memory: 16 passes
//  over n samples, twice for an even count, then a multiply and a shared
//  bit-serial divider for x and y, with busy high. reset is synchronous;
//  the sample memory needs no clearing; the receiver cannot stall results.
// ----------------------------------------------------------------------------
module roi_median_depth_projector_unit
   import rmdp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   typedef enum logic [2:0] {S_IDLE, S_SEL, S_MUL, S_DIV, S_SAT} state_type;

   typedef struct packed {
      logic        ok;
      logic [11:0] lo;
      logic [11:0] hi;
   } span_type;

   state_type state_ff;

   logic [15:0] depth_lo_ff, depth_hi_ff, focal_x_ff, focal_y_ff;
   logic [15:0] princ_x_ff, princ_y_ff;
   logic [8:0]  roi_ff;
   logic [12:0] min_samples_ff;

   logic [CountW-1:0] kept_ff;
   logic [11:0] rmin_u_ff, rmax_u_ff, rmin_v_ff, rmax_v_ff;
   logic [2:0]  pending_ff;
   logic [15:0] hold_cu_ff, hold_cv_ff;
   logic [12:0] img_w_ff, img_h_ff;

   logic [15:0] store [MaxSamples];
   logic [15:0] rd_data_ff;

   logic [CountW-1:0] n_ff, idx_ff, k_ff, cnt_ff;
   logic [3:0]  bit_ff;
   logic [15:0] prefix_ff, lower_ff;
   logic        second_ff, rd_vld_ff;
   logic [16:0] med_ff;
   logic        axis_ff;
   logic signed [34:0] num_ff;
   logic        neg_ff;
   logic [34:0] dvd_ff, quo_ff;
   logic [16:0] rem_ff;
   logic [17:0] dvs_ff;
   logic [5:0]  step_ff;
   logic signed [31:0] px_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   function automatic span_type make_span(input logic [15:0] center,
                                          input logic [15:0] size,
                                          input logic [12:0] limit,
                                          input logic [8:0]  roi);
      span_type           s;
      logic [24:0]        half;
      logic [24:0]        c;
      logic signed [26:0] a;
      logic [25:0]        b;
      logic [13:0]        l;
      logic [12:0]        h;
      logic [12:0]        hlim;
      logic [26:0]        au;
      half = size * roi;
      if (half < 25'd4096) begin
         half = 25'd4096;
      end
      c = {center, 9'd0};
      a = $signed({2'b00, c}) - $signed({2'b00, half});
      b = {1'b0, c} + {1'b0, half};
      au = a + 27'sd8191;
      l = (a <= 0) ? 14'd0 : au[26:13];
      h = b[25:13];
      hlim = limit - 13'd1;
      if (h > hlim) begin
         h = hlim;
      end
      s.ok = (l <= {1'b0, h});
      s.lo = l[11:0];
      s.hi = h[11:0];
      return s;
   endfunction

   // box decode
   logic        cfg_ok;
   logic [2:0]  box_status;
   span_type    span_u, span_v;
   assign cfg_ok = (depth_lo_ff != 16'd0) && (depth_hi_ff > depth_lo_ff) &&
                   (roi_ff != 9'd0) && (roi_ff <= 9'd256) &&
                   (min_samples_ff != 13'd0);
   assign span_u = make_span(req_data.box_ctr_u, req_data.box_width,
                             req_data.img_cols, roi_ff);
   assign span_v = make_span(req_data.box_ctr_v, req_data.box_height,
                             req_data.img_rows, roi_ff);

   always_comb begin
      if (!cfg_ok) begin
         box_status = ST_BAD_CONFIG;
      end else if (req_data.img_cols == 13'd0 || req_data.img_rows == 13'd0 ||
                   req_data.img_cols > 13'(MaxImageDim) ||
                   req_data.img_rows > 13'(MaxImageDim)) begin
         box_status = ST_BAD_IMAGE;
      end else if (req_data.box_width == 16'd0 || req_data.box_height == 16'd0 ||
                   {1'b0, req_data.box_ctr_u} >= {req_data.img_cols, 4'd0} ||
                   {1'b0, req_data.box_ctr_v} >= {req_data.img_rows, 4'd0} ||
                   !span_u.ok || !span_v.ok) begin
         box_status = ST_BAD_BOX;
      end else begin
         box_status = ST_VALID;
      end
   end

   // pixel decode
   logic              accept, keep;
   logic [CountW-1:0] count_new;
   logic              intr_bad;
   logic              few_depths;
   logic              fast_rsp;
   assign accept = start && !busy;
   assign keep = (pending_ff == ST_VALID) && req_data.pixel_finite[0] &&
                 (req_data.pixel_u >= rmin_u_ff) && (req_data.pixel_u <= rmax_u_ff) &&
                 (req_data.pixel_v >= rmin_v_ff) && (req_data.pixel_v <= rmax_v_ff) &&
                 (req_data.pixel_depth >= depth_lo_ff) &&
                 (req_data.pixel_depth <= depth_hi_ff) &&
                 (kept_ff < CountW'(MaxSamples));
   assign count_new = kept_ff + CountW'(keep);
   assign intr_bad = (focal_x_ff == 16'd0) || (focal_y_ff == 16'd0) ||
                     ({1'b0, princ_x_ff} >= {img_w_ff, 4'd0}) ||
                     ({1'b0, princ_y_ff} >= {img_h_ff, 4'd0});
   assign few_depths = (count_new < CountW'(min_samples_ff)) || (count_new == '0);
   // last pixel that answers without a median
   assign fast_rsp = accept && (req_data.op == OP_PIXEL) && req_data.last_pixel[0] &&
                     ((pending_ff != ST_VALID) || few_depths || intr_bad);

   // select datapath
   logic [16:0]       mask_sh;
   logic              match;
   logic              take_hi;
   logic [15:0]       val_new;
   logic [CountW-1:0] mid;
   assign mask_sh = 17'h1FFFF << ({1'b0, bit_ff} + 5'd1);
   assign match = (((rd_data_ff ^ prefix_ff) & mask_sh[15:0]) == 16'd0) &&
                  !rd_data_ff[bit_ff];
   assign take_hi = (k_ff >= cnt_ff);
   assign val_new = prefix_ff | (take_hi ? (16'd1 << bit_ff) : 16'd0);
   assign mid = n_ff >> 1;

   // projection datapath
   logic signed [16:0] diff;
   logic [15:0]        focal;
   logic [33:0]        mag;
   logic [17:0]        trial;
   assign diff = axis_ff ? ($signed({1'b0, hold_cv_ff}) - $signed({1'b0, princ_y_ff}))
                         : ($signed({1'b0, hold_cu_ff}) - $signed({1'b0, princ_x_ff}));
   assign focal = axis_ff ? focal_y_ff : focal_x_ff;
   assign mag = num_ff[34] ? 34'(-num_ff) : num_ff[33:0];
   assign trial = {rem_ff, dvd_ff[34]};

   logic signed [31:0] sat;
   always_comb begin
      if (neg_ff) begin
         sat = (quo_ff > 35'h080000000) ? 32'sh80000000 : 32'(-$signed({1'b0, quo_ff}));
      end else begin
         sat = (quo_ff > 35'h07FFFFFFF) ? 32'sh7FFFFFFF : quo_ff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_lo_ff    <= 16'd100;
         depth_hi_ff    <= 16'd10000;
         roi_ff         <= 9'd128;
         min_samples_ff <= 13'd10;
         focal_x_ff     <= 16'd9600;
         focal_y_ff     <= 16'd9600;
         princ_x_ff     <= 16'd5120;
         princ_y_ff     <= 16'd3840;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_DEPTH:   depth_lo_ff    <= csr_wdata;
            CSR_MAX_DEPTH:   depth_hi_ff    <= csr_wdata;
            CSR_ROI_RATIO:   roi_ff         <= csr_wdata[8:0];
            CSR_MIN_SAMPLES: min_samples_ff <= csr_wdata[12:0];
            CSR_FOCAL_X:     focal_x_ff     <= csr_wdata;
            CSR_FOCAL_Y:     focal_y_ff     <= csr_wdata;
            CSR_PRINC_X:     princ_x_ff     <= csr_wdata;
            CSR_PRINC_Y:     princ_y_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sample memory
   always_ff @(posedge clock) begin
      if (accept && req_data.op == OP_PIXEL && keep) begin
         store[kept_ff[AddrW-1:0]] <= req_data.pixel_depth;
      end
      rd_data_ff <= store[idx_ff[AddrW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kept_ff      <= '0;
         rmin_u_ff    <= '0;
         rmax_u_ff    <= '0;
         rmin_v_ff    <= '0;
         rmax_v_ff    <= '0;
         pending_ff   <= ST_VALID;
         hold_cu_ff   <= '0;
         hold_cv_ff   <= '0;
         img_w_ff     <= '0;
         img_h_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= fast_rsp || (state_ff == S_SAT && axis_ff);
         unique case (state_ff)
            S_IDLE: begin
               if (accept && req_data.op == OP_BOX) begin
                  hold_cu_ff  <= req_data.box_ctr_u;
                  hold_cv_ff  <= req_data.box_ctr_v;
                  img_w_ff    <= req_data.img_cols;
                  img_h_ff    <= req_data.img_rows;
                  kept_ff     <= '0;
                  pending_ff  <= box_status;
                  if (box_status == ST_VALID) begin
                     rmin_u_ff <= span_u.lo;
                     rmax_u_ff <= span_u.hi;
                     rmin_v_ff <= span_v.lo;
                     rmax_v_ff <= span_v.hi;
                  end
               end else if (accept) begin
                  kept_ff <= req_data.last_pixel[0] ? '0 : count_new;
                  if (req_data.last_pixel[0]) begin
                     if (pending_ff != ST_VALID) begin
                        rsp_data_ff <= '{status: pending_ff, sample_count: '0,
                                         median_depth: '0, point_x: '0, point_y: '0};
                     end else if (few_depths) begin
                        rsp_data_ff <= '{status: ST_FEW_DEPTHS,
                                         sample_count: 13'(count_new),
                                         median_depth: '0, point_x: '0, point_y: '0};
                     end else if (intr_bad) begin
                        rsp_data_ff <= '{status: ST_BAD_INTR,
                                         sample_count: 13'(count_new),
                                         median_depth: '0, point_x: '0, point_y: '0};
                     end else begin
                        rsp_data_ff <= '{status: ST_VALID,
                                         sample_count: 13'(count_new),
                                         median_depth: '0, point_x: '0, point_y: '0};
                        n_ff      <= count_new;
                        // even count: lower middle first
                        k_ff      <= count_new[0] ? (count_new >> 1)
                                                  : ((count_new >> 1) - CountW'(1));
                        second_ff <= count_new[0];
                        bit_ff    <= 4'd15;
                        prefix_ff <= '0;
                        cnt_ff    <= '0;
                        idx_ff    <= '0;
                        state_ff  <= S_SEL;
                     end
                  end
               end
            end
            S_SEL: begin
               rd_vld_ff <= (idx_ff < n_ff);
               if (idx_ff < n_ff) begin
                  idx_ff <= idx_ff + CountW'(1);
               end
               if (rd_vld_ff && match) begin
                  cnt_ff <= cnt_ff + CountW'(1);
               end
               if (idx_ff == n_ff && !rd_vld_ff) begin
                  idx_ff <= '0;
                  cnt_ff <= '0;
                  if (bit_ff != 4'd0) begin
                     prefix_ff <= val_new;
                     if (take_hi) begin
                        k_ff <= k_ff - cnt_ff;
                     end
                     bit_ff <= bit_ff - 4'd1;
                  end else if (!second_ff) begin
                     lower_ff  <= val_new;
                     second_ff <= 1'b1;
                     k_ff      <= mid;
                     bit_ff    <= 4'd15;
                     prefix_ff <= '0;
                  end else begin
                     med_ff   <= n_ff[0] ? {val_new, 1'b0}
                                         : ({1'b0, lower_ff} + {1'b0, val_new});
                     axis_ff  <= 1'b0;
                     state_ff <= S_MUL;
                  end
               end
            end
            S_MUL: begin
               num_ff   <= diff * $signed({1'b0, med_ff});
               state_ff <= S_DIV;
               step_ff  <= 6'd0;
            end
            S_DIV: begin
               if (step_ff == 6'd0) begin
                  neg_ff  <= num_ff[34];
                  dvd_ff  <= {mag, 1'b0} + {19'd0, focal};
                  dvs_ff  <= {1'b0, focal, 1'b0};
                  rem_ff  <= '0;
                  quo_ff  <= '0;
                  step_ff <= 6'd1;
               end else begin
                  dvd_ff <= {dvd_ff[33:0], 1'b0};
                  if (trial >= dvs_ff) begin
                     rem_ff <= 17'(trial - dvs_ff);
                     quo_ff <= {quo_ff[33:0], 1'b1};
                  end else begin
                     rem_ff <= trial[16:0];
                     quo_ff <= {quo_ff[33:0], 1'b0};
                  end
                  step_ff <= step_ff + 6'd1;
                  if (step_ff == 6'd35) begin
                     state_ff <= S_SAT;
                  end
               end
            end
            S_SAT: begin
               if (!axis_ff) begin
                  px_ff    <= sat;
                  axis_ff  <= 1'b1;
                  state_ff <= S_MUL;
               end else begin
                  rsp_data_ff <= '{status: ST_VALID,
                                   sample_count: rsp_data_ff.sample_count,
                                   median_depth: med_ff, point_x: px_ff, point_y: sat};
                  state_ff    <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_kept_bound: assert property (@(posedge clock) disable iff (reset)
      kept_ff <= CountW'(MaxSamples))
      else $error("kept count beyond store depth");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_VALID |->
         rsp_data.median_depth == 17'd0 && rsp_data.point_x == 32'sd0 &&
         rsp_data.point_y == 32'sd0)
      else $error("error word carries data");
   a_med_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_VALID |-> rsp_data.median_depth != 17'd0)
      else $error("valid word with zero median");
`endif

endmodule
